// ===== design/asoa_pkg.sv =====
// Shared types, constants and helper functions for the ADC scan oversample
// accumulator. No dependencies; every other design file imports this package.
package asoa_pkg;

  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 10;
  localparam int SUM_W       = 16;
  localparam int SLOT_W      = 2;
  localparam int CODE_W      = 4;
  localparam int CODE_REGS   = 4;
  localparam int SPB_W       = 7;
  localparam int BCNT_W      = 6;
  localparam int BLOCK_MAX   = 64;
  localparam int IDX_W       = $clog2(CHANNELS + 1);
  localparam int ADDR_W      = 5;
  localparam int REG_IDX_W   = ADDR_W - 2;
  localparam int DATA_W      = 32;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_SPB   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CODE0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CODE1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CODE2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CODE3 = 3'd4;

  // Result kinds
  localparam logic KIND_SELECT = 1'b0;
  localparam logic KIND_SUM    = 1'b1;

  // Reset values of the configuration registers
  localparam logic [SPB_W-1:0] SPB_RESET = 7'd16;

  typedef struct packed {
    logic [SPB_W-1:0]                  spb;
    logic [CODE_REGS-1:0][CODE_W-1:0]  code;
  } cfg_t;

  // Everything one sample request leaves for the output side
  typedef struct packed {
    logic [CHANNELS-1:0][SUM_W-1:0] sums;
    logic                           has_sums;
    logic                           flag;
    logic [SLOT_W-1:0]              next_slot;
  } burst_t;

  // Mux code of a scan slot; slots without a code register read as zero
  function automatic logic [CODE_W-1:0] code_of(cfg_t cfg, logic [SLOT_W-1:0] slot);
    logic [CODE_W-1:0] r;
    r = '0;
    if (int'(slot) < CODE_REGS) begin
      r = cfg.code[slot];
    end
    return r;
  endfunction

  // Effective block length: zero acts as one, values above the maximum clamp
  function automatic logic [SPB_W-1:0] block_len(logic [SPB_W-1:0] spb);
    logic [SPB_W-1:0] n;
    n = spb;
    if (spb == '0) begin
      n = SPB_W'(1);
    end else if (spb > SPB_W'(BLOCK_MAX)) begin
      n = SPB_W'(BLOCK_MAX);
    end
    return n;
  endfunction

endpackage

// ===== design/asoa_regs.sv =====
// APB configuration registers: block length and the four scan slot mux codes.
// Depends on asoa_pkg.
module asoa_regs
  import asoa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spb <= SPB_RESET;
      for (int i = 0; i < CODE_REGS; i++) begin
        cfg.code[i] <= CODE_W'(i);
      end
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SPB:   cfg.spb     <= pwdata[SPB_W-1:0];
        REG_CODE0: cfg.code[0] <= pwdata[CODE_W-1:0];
        REG_CODE1: cfg.code[1] <= pwdata[CODE_W-1:0];
        REG_CODE2: cfg.code[2] <= pwdata[CODE_W-1:0];
        REG_CODE3: cfg.code[3] <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_SPB:   prdata = DATA_W'(cfg.spb);
      REG_CODE0: prdata = DATA_W'(cfg.code[0]);
      REG_CODE1: prdata = DATA_W'(cfg.code[1]);
      REG_CODE2: prdata = DATA_W'(cfg.code[2]);
      REG_CODE3: prdata = DATA_W'(cfg.code[3]);
      default:   prdata = '0;
    endcase
  end

endmodule

// ===== design/asoa_accum.sv =====
// Input register and per-slot accumulator state: running sums, scan slot,
// block counter and sticky ready flag. Depends on asoa_pkg.
module asoa_accum
  import asoa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  cfg_t                   cfg,
  input  logic                   load_ok,
  output logic                   load,
  output burst_t                 burst
);

  logic                           in_full;
  logic [SAMPLE_BITS-1:0]         sample_q;
  logic [CHANNELS-1:0][SUM_W-1:0] sums;
  logic [CHANNELS-1:0][SUM_W-1:0] sums_next;
  logic [SLOT_W-1:0]              slot;
  logic [SLOT_W-1:0]              slot_next;
  logic [BCNT_W-1:0]              bcount;
  logic                           ready_flag;
  logic [SUM_W:0]                 acc;
  logic [SUM_W-1:0]               acc_sat;
  logic [BCNT_W:0]                bc_inc;
  logic                           wrap;
  logic                           done;

  // Take the held request when the output side can accept its results
  assign load         = in_full && load_ok;
  assign sample_ready = !in_full || load;

  // Hold the incoming request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (sample_ready) begin
      in_full <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      sample_q <= sample;
    end
  end

  // Saturating add into the current slot and block completion check
  always_comb begin
    acc       = {1'b0, sums[slot]} + (SUM_W+1)'(sample_q);
    acc_sat   = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
    wrap      = (slot == SLOT_W'(CHANNELS - 1));
    bc_inc    = {1'b0, bcount} + (BCNT_W+1)'(1);
    done      = wrap && (bc_inc >= (BCNT_W+1)'(block_len(cfg.spb)));
    slot_next = wrap ? '0 : slot + SLOT_W'(1);
    sums_next = sums;
    sums_next[slot] = acc_sat;

    burst.sums      = sums_next;
    burst.has_sums  = done;
    burst.flag      = ready_flag || done;
    burst.next_slot = slot_next;
  end

  // Advance the scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      sums       <= '0;
      slot       <= '0;
      bcount     <= '0;
      ready_flag <= 1'b0;
    end else if (load) begin
      sums       <= done ? '0 : sums_next;
      slot       <= slot_next;
      ready_flag <= ready_flag || done;
      if (wrap) begin
        bcount <= done ? '0 : bc_inc[BCNT_W-1:0];
      end
    end
  end

  a_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    ready_flag |=> ready_flag)
    else $error("ready flag dropped");

  a_sums_cleared: assert property (@(posedge clk) disable iff (rst)
    load && done |=> (sums == '0) && (bcount == '0))
    else $error("sums not cleared after block completion");

  a_count_only_on_wrap: assert property (@(posedge clk) disable iff (rst)
    load && !wrap |=> $stable(bcount))
    else $error("block counter moved without scan wrap");

endmodule

// ===== design/asoa_emit.sv =====
// Result register: holds one request's burst of results (up to four sums then
// one select), sent one per cycle while result_ready is high. Depends on asoa_pkg.
module asoa_emit
  import asoa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              load,
  input  burst_t            burst,
  output logic              load_ok,
  output logic              result_valid,
  input  logic              result_ready,
  output logic              kind,
  output logic [SLOT_W-1:0] channel,
  output logic [CODE_W-1:0] channel_code,
  output logic [SUM_W-1:0]  sum,
  output logic              results_ready,
  output logic              last
);

  logic             busy;
  burst_t           b;
  logic [IDX_W-1:0] idx;
  logic             is_sum;
  logic             fire;

  assign is_sum  = b.has_sums && (idx != IDX_W'(CHANNELS));
  assign fire    = busy && result_ready;
  assign load_ok = !busy || (fire && !is_sum);

  // Advance through the burst; reload as the last result leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (fire && !is_sum) begin
      busy <= 1'b0;
    end else if (fire) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b <= burst;
    end
  end

  // Present the current result
  always_comb begin
    result_valid  = busy;
    kind          = is_sum ? KIND_SUM : KIND_SELECT;
    channel       = is_sum ? idx[SLOT_W-1:0] : b.next_slot;
    channel_code  = code_of(cfg, channel);
    sum           = is_sum ? b.sums[idx[SLOT_W-1:0]] : '0;
    results_ready = b.flag;
    last          = !is_sum;
  end

  a_sums_imply_flag: assert property (@(posedge clk) disable iff (rst)
    busy && b.has_sums |-> b.flag)
    else $error("sum results without ready flag");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx <= IDX_W'(CHANNELS)) && (b.has_sums || idx == '0))
    else $error("burst index out of range");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(kind) &&
      $stable(channel) && $stable(sum) && $stable(results_ready) && $stable(last))
    else $error("waiting result changed");

endmodule

// ===== design/adc_scan_oversample_accumulator.sv =====
// Multichannel ADC oversampling accumulator, top level: APB registers,
// sample accumulator and result register. Depends on asoa_pkg and submodules.
//
// Each sample request is added (saturating at 65535) to the sum of the current
// scan slot, and the scan steps round robin over four slots. After each slot
// has collected samples_per_block samples the block emits four sum results in
// slot order, clears the sums and sets the sticky results_ready flag; every
// sample ends with one select result naming the next slot and its mux code,
// marked by last. Samples that only yield a select result stream at one per
// clock while result_ready is high; a block-completing sample occupies the
// result register for five results, and the input register holds the next
// sample meanwhile. Each sample passes through the input register and then
// the result register, where its results appear. Configuration may be
// written only while no results are pending.
module adc_scan_oversample_accumulator
  import asoa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic                   kind,
  output logic [SLOT_W-1:0]      channel,
  output logic [CODE_W-1:0]      channel_code,
  output logic [SUM_W-1:0]       sum,
  output logic                   results_ready,
  output logic                   last
);

  cfg_t   cfg;
  burst_t burst;
  logic   load;
  logic   load_ok;

  asoa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  asoa_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .cfg          (cfg),
    .load_ok      (load_ok),
    .load         (load),
    .burst        (burst)
  );

  asoa_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .load          (load),
    .burst         (burst),
    .load_ok       (load_ok),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .kind          (kind),
    .channel       (channel),
    .channel_code  (channel_code),
    .sum           (sum),
    .results_ready (results_ready),
    .last          (last)
  );

endmodule
